### sv/srt_pkg.sv
// Shared types and constants for the stable rank table.
// Used by srt_ctrl, srt_dp and stable_rank_table.
package srt_pkg;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int RANK_W  = 11;
    localparam int CNT_W   = 11;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic accept_wr;
        logic accept_qry;
        logic reject;
        logic key_load;
        logic scan;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_range;
        logic scan_last;
    } t_ctrl_sts;

endpackage

### sv/srt_ctrl.sv
// Controller for the stable rank table: sequences write, key read, scan and result load.
// Depends on srt_pkg; drives srt_dp through t_ctrl_cmd.
module srt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic               i_command,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  srt_pkg::t_ctrl_sts i_sts,
    output srt_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_KEY  = 4'b0010,
        S_SCAN = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == srt_pkg::CMD_WRITE) begin
                        o_cmd.accept_wr = 1'b1;
                    end else if (i_sts.in_range) begin
                        o_cmd.accept_qry = 1'b1;
                        n_state          = S_KEY;
                    end else begin
                        o_cmd.reject = 1'b1;
                        n_state      = S_OUT;
                    end
                end
            end
            S_KEY: begin
                o_cmd.key_load = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### sv/srt_dp.sv
// Datapath for the stable rank table: value memory, entry count, key, scan counter, rank.
// Depends on srt_pkg; commanded by srt_ctrl.
module srt_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [srt_pkg::CNT_W-1:0]   i_cfg_wr_data,
    input  logic [srt_pkg::INDEX_W-1:0] i_index,
    input  logic [srt_pkg::VALUE_W-1:0] i_value,
    input  srt_pkg::t_ctrl_cmd          i_cmd,
    output srt_pkg::t_ctrl_sts          o_sts,
    output logic [srt_pkg::RANK_W-1:0]  o_rank
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    logic [srt_pkg::VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic [srt_pkg::VALUE_W-1:0] r_rd_data;
    logic [srt_pkg::VALUE_W-1:0] r_key;
    logic [srt_pkg::CNT_W-1:0]   r_entry_count;
    logic [AW-1:0]               r_pos;
    logic [AW-1:0]               r_cmp_idx, n_cmp_idx;
    logic [NW-1:0]               r_rank, n_rank;
    logic [srt_pkg::RANK_W-1:0]  r_out_rank;
    logic [NW-1:0]               live;
    logic [AW-1:0]               rd_addr;
    logic                        rd_en;
    logic                        wr_en;
    logic                        hit;

    always_comb begin
        if (r_entry_count == '0) begin
            live = NW'(1);
        end else if (32'(r_entry_count) > 32'(TABLE_DEPTH)) begin
            live = NW'(TABLE_DEPTH);
        end else begin
            live = NW'(r_entry_count);
        end
    end

    assign o_sts.in_range  = 32'(i_index) < 32'(live);
    assign o_sts.scan_last = 32'(r_cmp_idx) == (32'(live) - 32'd1);

    assign wr_en = i_cmd.accept_wr && (32'(i_index) < 32'(TABLE_DEPTH));

    assign hit = ($signed(r_rd_data) < $signed(r_key)) ||
                 ((r_rd_data == r_key) && (r_cmp_idx < r_pos));

    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = r_cmp_idx + AW'(1);
        n_cmp_idx = r_cmp_idx;
        n_rank    = r_rank;
        if (i_cmd.accept_qry) begin
            rd_en   = 1'b1;
            rd_addr = AW'(i_index);
        end else if (i_cmd.key_load) begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            n_cmp_idx = '0;
            n_rank    = NW'(1);
        end else if (i_cmd.scan) begin
            rd_en     = !o_sts.scan_last;
            n_cmp_idx = r_cmp_idx + AW'(1);
            n_rank    = r_rank + NW'(hit);
        end else if (i_cmd.reject) begin
            n_rank = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[AW'(i_index)] <= i_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= srt_pkg::CNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_entry_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_qry) begin
            r_pos <= AW'(i_index);
        end
        if (i_cmd.key_load) begin
            r_key <= r_rd_data;
        end
        if (i_cmd.out_load) begin
            r_out_rank <= srt_pkg::RANK_W'(r_rank);
        end
        r_cmp_idx <= n_cmp_idx;
        r_rank    <= n_rank;
    end

    assign o_rank = r_out_rank;

endmodule

### sv/stable_rank_table.sv
// Stable rank table: stores signed values, answers stable ascending rank queries.
// Operation: a write stores its value while idle; a query reads its key, compares it
// with each live entry in turn (key read, one compare per entry, result load); out of range: rank 0.
// No new transfer is taken until a query's result is loaded; the single memory read port scans.
// Reset: synchronous active low; clears control and sets entry_count to 1024.
// Table contents stay undefined until written; no clearing pass.
module stable_rank_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [10:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [9:0] index, [41:10] value, [47:42] zero
    input  logic [0:0]  s_axis_tuser,  // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [10:0] rank, [15:11] zero
);

    srt_pkg::t_ctrl_cmd          cmd;
    srt_pkg::t_ctrl_sts          sts;
    logic [srt_pkg::RANK_W-1:0]  rank;

    srt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_command     (s_axis_tuser[0]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    srt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_index       (s_axis_tdata[9:0]),
        .i_value       (s_axis_tdata[41:10]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_rank        (rank)
    );

    assign m_axis_tdata = {5'b0, rank};

`ifndef ASSERT_OFF
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == srt_pkg::CMD_QUERY)
        |=> !s_axis_tready)
        else $error("query transfer did not make the block busy");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> m_axis_tvalid)
        else $error("result load did not raise output valid");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid set after reset");
`endif

endmodule
